/* design/pol_pkg.sv */
// Shared types and constants for the positional ordered list.
`timescale 1ns / 1ps

package pol_pkg;

   // Fixed widths of the channel fields.
   localparam int REQ_TYPE_BITS = 3;
   localparam int POS_BITS      = 5;
   localparam int DATA_BITS     = 32;
   localparam int STATUS_BITS   = 2;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_INS_FRONT = 3'd0,
      REQ_INS_BACK  = 3'd1,
      REQ_INS_POS   = 3'd2,
      REQ_DEL_FRONT = 3'd3,
      REQ_DEL_BACK  = 3'd4,
      REQ_DEL_POS   = 3'd5,
      REQ_READ_FWD  = 3'd6,
      REQ_READ_BWD  = 3'd7
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

endpackage

/* design/pol_if.sv */
// Request and response channel interfaces of the positional ordered list.
`timescale 1ns / 1ps

interface pol_req_if import pol_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [REQ_TYPE_BITS-1:0]    req_type;
   logic [POS_BITS-1:0]         position;
   logic signed [DATA_BITS-1:0] item_value;

   modport source (output valid, output req_type, output position, output item_value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input item_value,
                   output ready);
endinterface

interface pol_rsp_if import pol_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [STATUS_BITS-1:0]      status;
   logic signed [DATA_BITS-1:0] result_value;
   logic [POS_BITS-1:0]         result_position;
   logic [POS_BITS-1:0]         element_count;
   logic                        last_of_run;

   modport source (output valid, output status, output result_value,
                   output result_position, output element_count, output last_of_run,
                   input ready);
   modport sink   (input valid, input status, input result_value,
                   input result_position, input element_count, input last_of_run,
                   output ready);
endinterface

/* design/pol_cell.sv */
// One storage cell of the list chain: holds one element and shifts with its neighbors.
`timescale 1ns / 1ps

module pol_cell import pol_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int IDX_BITS   = 4,
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  cell_op_type                  cell_op,
   input  logic [IDX_BITS-1:0]          target_idx,
   input  logic [IDX_BITS-1:0]          tap_idx,
   input  logic signed [VALUE_BITS-1:0] insert_value,
   input  logic signed [VALUE_BITS-1:0] left_value,
   input  logic signed [VALUE_BITS-1:0] right_value,
   output logic signed [VALUE_BITS-1:0] value_out,
   output logic signed [VALUE_BITS-1:0] tap_out
);

   localparam logic [IDX_BITS-1:0] MY_INDEX = IDX_BITS'(CELL_INDEX);

   logic signed [VALUE_BITS-1:0] value_ff;
   logic signed [VALUE_BITS-1:0] value_in;

   // Cells behind the insert point take their left neighbor; cells at or
   // behind the removal point take their right neighbor.
   always_comb begin
      value_in = value_ff;
      unique case (cell_op)
         CELL_HOLD: begin
            value_in = value_ff;
         end
         CELL_INSERT: begin
            if (MY_INDEX > target_idx) begin
               value_in = left_value;
            end else if (MY_INDEX == target_idx) begin
               value_in = insert_value;
            end
         end
         CELL_REMOVE: begin
            if (MY_INDEX >= target_idx) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign tap_out   = (tap_idx == MY_INDEX) ? value_ff : '0;

endmodule

/* design/positional_ordered_list.sv */
// Top level of the positional ordered list: control sequencer over a chain of cells.
`timescale 1ns / 1ps
//
// The block keeps up to LIST_DEPTH signed values in order, at positions 1 to count.
// Requests arrive on the req_if channel and results leave on the rsp_if channel; both
// use valid/ready, and an item moves at a clock edge where both are high.
// Inserts (front, back, at a position) and deletes (front, back, at a position) shift
// the cell chain at the edge that accepts the item, and the single result item sits
// in the output register from the next cycle on.
// A forward or backward read loads the read cursor in the accepting cycle, then emits
// one element per cycle while the receiver keeps up, the final one marked by last_of_run.
// The cursor walk, one element per cycle unless the receiver stalls, sets the read rate.
// Deletes and reads on an empty list, and a positional insert on an empty list, give one
// result with the empty status. Inserts into a full list give the full status and leave
// the list unchanged.
// A new request is taken when the sequencer is idle and the output register is empty or
// being emptied in the same cycle. When the receiver stalls, the output register holds
// its item and a read pauses on its current element.
// Reset empties the list and the output register and holds off new requests; the cell
// contents are not cleared and are never read before they are written.

module positional_ordered_list import pol_pkg::*; #(
   parameter int LIST_DEPTH = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   pol_req_if.sink   req_if,
   pol_rsp_if.source rsp_if
);

   localparam int IW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int MW = (CW > POS_BITS) ? CW : POS_BITS;

   // Sequencer and list bookkeeping.
   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   cursor_ff, cursor_in;
   logic            backward_ff, backward_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  status_ff, status_in;
   logic signed [DATA_BITS-1:0] value_ff, value_in;
   logic [POS_BITS-1:0]         rpos_ff, rpos_in;
   logic [POS_BITS-1:0]         rcnt_ff, rcnt_in;
   logic                        last_ff, last_in;

   // Cell chain controls and data.
   cell_op_type                  cell_op;
   logic [IW-1:0]                target_idx;
   logic [IW-1:0]                tap_idx;
   logic signed [VALUE_BITS-1:0] insert_value;
   logic signed [VALUE_BITS-1:0] chain [LIST_DEPTH];
   logic signed [VALUE_BITS-1:0] taps  [LIST_DEPTH];
   logic signed [VALUE_BITS-1:0] tap_value;
   logic signed [DATA_BITS-1:0]  tap_word;

   req_code_type  req_code;
   logic [MW-1:0] pos_req, count_wide, ins_pos, del_pos;
   logic          slot_free, accept, list_empty, list_full;
   logic          is_insert, is_delete, refused, read_last;

   assign req_code     = req_code_type'(req_if.req_type);
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !reset && (state_ff == ST_IDLE) && slot_free;
   assign accept       = req_if.valid && req_if.ready;

   assign list_empty = (count_ff == '0);
   assign list_full  = (count_ff == CW'(LIST_DEPTH));
   assign is_insert  = (req_code == REQ_INS_FRONT) || (req_code == REQ_INS_BACK) ||
                       (req_code == REQ_INS_POS);
   assign is_delete  = (req_code == REQ_DEL_FRONT) || (req_code == REQ_DEL_BACK) ||
                       (req_code == REQ_DEL_POS);
   // A positional insert counts as an operation that needs a non-empty list.
   assign refused    = (list_empty && (req_code != REQ_INS_FRONT) &&
                        (req_code != REQ_INS_BACK)) || (list_full && is_insert);

   // Position zero means the front; positions past the end are clamped.
   assign pos_req    = (req_if.position == '0) ? MW'(1) : MW'(req_if.position);
   assign count_wide = MW'(count_ff);
   assign ins_pos    = (pos_req > count_wide + MW'(1)) ? count_wide + MW'(1) : pos_req;
   assign del_pos    = (pos_req > count_wide) ? count_wide : pos_req;

   assign insert_value = VALUE_BITS'(req_if.item_value);

   // Chain operation and the cell it is aimed at.
   always_comb begin
      target_idx = '0;
      case (req_code)
         REQ_INS_BACK: target_idx = IW'(count_ff);
         REQ_INS_POS:  target_idx = IW'(ins_pos - MW'(1));
         REQ_DEL_BACK: target_idx = IW'(count_ff - CW'(1));
         REQ_DEL_POS:  target_idx = IW'(del_pos - MW'(1));
         default:      target_idx = '0;
      endcase

      cell_op = CELL_HOLD;
      if (accept && !refused) begin
         if (is_insert) begin
            cell_op = CELL_INSERT;
         end else if (is_delete) begin
            cell_op = CELL_REMOVE;
         end
      end

      tap_idx = (state_ff == ST_READ) ? cursor_ff : target_idx;
   end

   // The row of cells. The ends tie their missing neighbor to themselves.
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic signed [VALUE_BITS-1:0] left_value;
      logic signed [VALUE_BITS-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = chain[i];
      end else begin : g_inner_left
         assign left_value = chain[i-1];
      end

      if (i == LIST_DEPTH - 1) begin : g_last
         assign right_value = chain[i];
      end else begin : g_inner_right
         assign right_value = chain[i+1];
      end

      pol_cell #(
         .VALUE_BITS (VALUE_BITS),
         .IDX_BITS   (IW),
         .CELL_INDEX (i)
      ) u_cell (
         .clock        (clock),
         .cell_op      (cell_op),
         .target_idx   (target_idx),
         .tap_idx      (tap_idx),
         .insert_value (insert_value),
         .left_value   (left_value),
         .right_value  (right_value),
         .value_out    (chain[i]),
         .tap_out      (taps[i])
      );
   end

   // Only the addressed cell drives its tap, so an OR gathers the selected element.
   always_comb begin
      tap_value = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         tap_value = tap_value | taps[i];
      end
   end

   assign tap_word = DATA_BITS'(tap_value);

   assign read_last = backward_ff ? (cursor_ff == '0)
                                  : (CW'(cursor_ff) == count_ff - CW'(1));

   // Sequencer, list count and output register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      backward_in  = backward_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      value_in     = value_ff;
      rpos_in      = rpos_ff;
      rcnt_in      = rcnt_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STATUS_OK;
               value_in  = '0;
               rpos_in   = '0;
               last_in   = 1'b1;
               if (refused) begin
                  rsp_valid_in = 1'b1;
                  status_in    = (list_empty && !is_insert) ||
                                 (list_empty && req_code == REQ_INS_POS) ?
                                 STATUS_EMPTY : STATUS_FULL;
               end else begin
                  case (req_code)
                     REQ_INS_FRONT: begin
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff + CW'(1);
                        rpos_in      = POS_BITS'(1);
                     end
                     REQ_INS_BACK: begin
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff + CW'(1);
                        rpos_in      = POS_BITS'(count_ff + CW'(1));
                     end
                     REQ_INS_POS: begin
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff + CW'(1);
                        rpos_in      = POS_BITS'(ins_pos);
                     end
                     REQ_DEL_FRONT: begin
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff - CW'(1);
                        value_in     = tap_word;
                        rpos_in      = POS_BITS'(1);
                     end
                     REQ_DEL_BACK: begin
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff - CW'(1);
                        value_in     = tap_word;
                        rpos_in      = POS_BITS'(count_ff);
                     end
                     REQ_DEL_POS: begin
                        rsp_valid_in = 1'b1;
                        count_in     = count_ff - CW'(1);
                        value_in     = tap_word;
                        rpos_in      = POS_BITS'(del_pos);
                     end
                     REQ_READ_FWD: begin
                        state_in    = ST_READ;
                        cursor_in   = '0;
                        backward_in = 1'b0;
                     end
                     REQ_READ_BWD: begin
                        state_in    = ST_READ;
                        cursor_in   = IW'(count_ff - CW'(1));
                        backward_in = 1'b1;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
               rcnt_in = POS_BITS'(count_in);
            end
         end
         ST_READ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               value_in     = tap_word;
               rpos_in      = POS_BITS'(CW'(cursor_ff) + CW'(1));
               rcnt_in      = POS_BITS'(count_ff);
               last_in      = read_last;
               if (read_last) begin
                  state_in  = ST_IDLE;
                  cursor_in = '0;
               end else if (backward_ff) begin
                  cursor_in = cursor_ff - IW'(1);
               end else begin
                  cursor_in = cursor_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         backward_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         backward_ff  <= backward_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      rpos_ff   <= rpos_in;
      rcnt_ff   <= rcnt_in;
      last_ff   <= last_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = status_ff;
   assign rsp_if.result_value    = value_ff;
   assign rsp_if.result_position = rpos_ff;
   assign rsp_if.element_count   = rcnt_ff;
   assign rsp_if.last_of_run     = last_ff;

   // The list never holds more elements than there are cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LIST_DEPTH))
      else $error("element count exceeds the list depth");

   // While a read is running the cursor stays on a stored element.
   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (CW'(cursor_ff) < count_ff))
      else $error("read cursor outside the stored elements");

   // A pending item that is not the last of its run belongs to a running read.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> (state_ff == ST_READ))
      else $error("unfinished run without a read in progress");

   // A successful insert grows the list by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cell_op == CELL_INSERT) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the list by one");

   // A read never changes the list size.
   a_read_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (count_ff == $past(count_ff)))
      else $error("element count changed during a read");

endmodule

/* tb/sv/tb_positional_ordered_list.sv */
// Self-checking testbench for the positional ordered list: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_positional_ordered_list;
   import pol_pkg::*;

   // The list capacity matches the default of the block.
   localparam int LIST_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 188;
   // The final stretch of the random part runs without any idling on either side.
   localparam int CALM_ITEMS   = 40;
   // The long receiver hold-off starts once this many items have been accepted.
   localparam int HOLD_AFTER   = 70;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 40;
   localparam int N_DIRECTED   = 23;
   // Only the first mismatches are printed, so that a broken block cannot flood the log.
   localparam int PRINT_LIMIT  = 40;

   // One result item as the block should present it.
   typedef struct packed {
      status_type                  status;
      logic signed [DATA_BITS-1:0] value;
      logic [POS_BITS-1:0]         position;
      logic [POS_BITS-1:0]         count;
      logic                        last;
   } list_result_type;

   // One row of the directed table. A row with repeats above one sends that many items,
   // with the value stepping up by one each time. Where typed is set, the row carries its
   // expected result, written out by hand; every other row is checked against the predictor.
   typedef struct packed {
      req_code_type                op;
      logic [POS_BITS-1:0]         position;
      logic signed [DATA_BITS-1:0] value;
      int                          repeats;
      bit                          typed;
      list_result_type             want;
   } stim_row_type;

   localparam list_result_type NO_RESULT  = '{STATUS_OK, '0, '0, '0, 1'b0};
   localparam list_result_type EMPTY_RSP  = '{STATUS_EMPTY, '0, '0, '0, 1'b1};
   localparam list_result_type FULL_RSP   = '{STATUS_FULL, '0, '0, 5'd16, 1'b1};

   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // Every operation but the front and back inserts is refused on the empty list.
      '{REQ_DEL_FRONT, 5'd1,  32'sd0,           1,  1'b1, EMPTY_RSP},
      '{REQ_DEL_BACK,  5'd1,  32'sd0,           1,  1'b1, EMPTY_RSP},
      '{REQ_DEL_POS,   5'd17, 32'sd0,           1,  1'b1, EMPTY_RSP},
      '{REQ_READ_FWD,  5'd1,  32'sd0,           1,  1'b1, EMPTY_RSP},
      '{REQ_READ_BWD,  5'd1,  32'sd0,           1,  1'b1, EMPTY_RSP},
      '{REQ_INS_POS,   5'd1,  32'sd7,           1,  1'b1, EMPTY_RSP},
      // The value extremes go in first, at the front and at the back.
      '{REQ_INS_FRONT, 5'd1,  32'sh7FFF_FFFF,   1,  1'b1,
        '{STATUS_OK, 32'sd0, 5'd1, 5'd1, 1'b1}},
      '{REQ_INS_BACK,  5'd1,  32'sh8000_0000,   1,  1'b1,
        '{STATUS_OK, 32'sd0, 5'd2, 5'd2, 1'b1}},
      // Position zero acts as position one; positions past the end are clamped.
      '{REQ_INS_POS,   5'd0,  32'sd1,           1,  1'b0, NO_RESULT},
      '{REQ_INS_POS,   5'd31, -32'sd1,          1,  1'b0, NO_RESULT},
      '{REQ_INS_POS,   5'd17, 32'sh5555_5555,   1,  1'b0, NO_RESULT},
      '{REQ_INS_FRONT, 5'd1,  32'shAAAA_AAAA,   1,  1'b0, NO_RESULT},
      // Fill the list up to its capacity.
      '{REQ_INS_BACK,  5'd1,  32'sd100,         10, 1'b0, NO_RESULT},
      // Every kind of insert is refused on the full list.
      '{REQ_INS_BACK,  5'd1,  32'sd9,           1,  1'b1, FULL_RSP},
      '{REQ_INS_POS,   5'd3,  32'sd9,           1,  1'b1, FULL_RSP},
      '{REQ_INS_FRONT, 5'd1,  32'sd9,           1,  1'b1, FULL_RSP},
      // Reads of the full list give the longest runs of result items.
      '{REQ_READ_FWD,  5'd1,  32'sd0,           1,  1'b0, NO_RESULT},
      '{REQ_READ_BWD,  5'd1,  32'sd0,           1,  1'b0, NO_RESULT},
      // Deletes, again with a clamped position and with position zero.
      '{REQ_DEL_POS,   5'd31, 32'sd0,           1,  1'b0, NO_RESULT},
      '{REQ_DEL_POS,   5'd0,  32'sd0,           1,  1'b0, NO_RESULT},
      '{REQ_DEL_FRONT, 5'd1,  32'sd0,           1,  1'b0, NO_RESULT},
      '{REQ_DEL_BACK,  5'd1,  32'sd0,           1,  1'b0, NO_RESULT},
      '{REQ_DEL_POS,   5'd16, 32'sd0,           1,  1'b0, NO_RESULT}
   };

   logic clock = 1'b0;
   logic reset;
   // Set for the long receiver hold-off, and for the final stretch without idling.
   logic hold_rsp;
   logic calm_phase;
   int   accepted_items = 0;
   int   mismatch_count = 0;

   // The predictor's own copy of the list, front first, and the results still to come.
   logic signed [DATA_BITS-1:0] list_model [$];
   list_result_type             pending_results [$];

   pol_req_if req_ch ();
   pol_rsp_if rsp_ch ();

   positional_ordered_list #(
      .LIST_DEPTH (LIST_DEPTH),
      .VALUE_BITS (DATA_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   function automatic void expect_result(input status_type status,
                                         input logic signed [DATA_BITS-1:0] value,
                                         input int position, input int count,
                                         input bit last);
      pending_results.push_back('{status, value, POS_BITS'(position), POS_BITS'(count),
                                  last});
   endfunction

   // Applies one accepted request to the list copy and queues the results it causes.
   function automatic void apply_list_op(input req_code_type op,
                                         input logic [POS_BITS-1:0] position,
                                         input logic signed [DATA_BITS-1:0] value);
      int                          n;
      int                          at;
      logic signed [DATA_BITS-1:0] taken;
      n  = list_model.size();
      at = (position == 0) ? 1 : int'(position);
      if (n == 0 && op != REQ_INS_FRONT && op != REQ_INS_BACK) begin
         // The positional insert is refused on the empty list along with deletes and reads.
         expect_result(STATUS_EMPTY, '0, 0, 0, 1'b1);
      end else if ((op == REQ_INS_FRONT || op == REQ_INS_BACK || op == REQ_INS_POS) &&
                   n >= LIST_DEPTH) begin
         expect_result(STATUS_FULL, '0, 0, n, 1'b1);
      end else begin
         case (op)
            REQ_INS_FRONT: begin
               list_model.push_front(value);
               expect_result(STATUS_OK, '0, 1, n + 1, 1'b1);
            end
            REQ_INS_BACK: begin
               list_model.push_back(value);
               expect_result(STATUS_OK, '0, n + 1, n + 1, 1'b1);
            end
            REQ_INS_POS: begin
               if (at > n + 1)
                  at = n + 1;
               list_model.insert(at - 1, value);
               expect_result(STATUS_OK, '0, at, n + 1, 1'b1);
            end
            REQ_DEL_FRONT: begin
               taken = list_model.pop_front();
               expect_result(STATUS_OK, taken, 1, n - 1, 1'b1);
            end
            REQ_DEL_BACK: begin
               taken = list_model.pop_back();
               expect_result(STATUS_OK, taken, n, n - 1, 1'b1);
            end
            REQ_DEL_POS: begin
               if (at > n)
                  at = n;
               taken = list_model[at - 1];
               list_model.delete(at - 1);
               expect_result(STATUS_OK, taken, at, n - 1, 1'b1);
            end
            REQ_READ_FWD: begin
               for (int i = 0; i < n; i++)
                  expect_result(STATUS_OK, list_model[i], i + 1, n, i == n - 1);
            end
            default: begin
               for (int i = n; i > 0; i--)
                  expect_result(STATUS_OK, list_model[i - 1], i, n, i == 1);
            end
         endcase
      end
   endfunction

   // Offers one request, possibly after an idle burst, and returns at the accepting edge.
   // The valid line is only lowered when a gap is taken, so back-to-back items keep it high.
   task automatic send_request(input req_code_type op, input logic [POS_BITS-1:0] position,
                               input logic signed [DATA_BITS-1:0] value);
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= op;
      req_ch.position   <= position;
      req_ch.item_value <= value;
      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
      accepted_items++;
      apply_list_op(op, position, value);
   endtask

   // Random traffic drifts between a filling and a draining mood, so that the list keeps
   // travelling between empty and full. Most positions land inside the list; the rest
   // cover the whole field, zero and far past the end included. A few items are fully
   // random noise.
   task automatic run_random_traffic();
      bit                          filling;
      int                          n;
      int                          roll;
      req_code_type                op;
      logic [POS_BITS-1:0]         position;
      logic signed [DATA_BITS-1:0] value;
      filling = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - CALM_ITEMS)
            calm_phase <= 1'b1;
         n = list_model.size();
         if (n == LIST_DEPTH && $urandom_range(0, 2) == 0)
            filling = 1'b0;
         else if (n == 0 && $urandom_range(0, 2) == 0)
            filling = 1'b1;
         else if ($urandom_range(0, 39) == 0)
            filling = !filling;

         roll = $urandom_range(0, 99);
         if (roll < 4)
            op = req_code_type'($urandom_range(0, 7));
         else if (roll < 16)
            op = ($urandom_range(0, 1) == 1) ? REQ_READ_FWD : REQ_READ_BWD;
         else if (filling ? (roll < 76) : (roll < 36))
            op = req_code_type'($urandom_range(0, 2));
         else
            op = req_code_type'($urandom_range(3, 5));

         if ($urandom_range(0, 3) == 0)
            position = POS_BITS'($urandom_range(0, 31));
         else
            position = POS_BITS'($urandom_range(1, n + 1));

         case ($urandom_range(0, 11))
            0:       value = 32'sh7FFF_FFFF;
            1:       value = 32'sh8000_0000;
            2:       value = '0;
            3:       value = -32'sd1;
            default: value = DATA_BITS'($urandom);
         endcase
         send_request(op, position, value);
      end
   endtask

   task automatic check_result();
      list_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("result item with nothing expected, value %0d",
                                   rsp_ch.result_value));
      end else begin
         want = pending_results.pop_front();
         if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_ch.status, want.status));
         if (rsp_ch.result_value !== want.value)
            report_mismatch($sformatf("result_value %0d, expected %0d",
                                      rsp_ch.result_value, want.value));
         if (rsp_ch.result_position !== want.position)
            report_mismatch($sformatf("result_position %0d, expected %0d",
                                      rsp_ch.result_position, want.position));
         if (rsp_ch.element_count !== want.count)
            report_mismatch($sformatf("element_count %0d, expected %0d",
                                      rsp_ch.element_count, want.count));
         if (rsp_ch.last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                      rsp_ch.last_of_run, want.last));
      end
   endtask

   // Receiver: checks every accepted result item, then decides ready for the next cycle.
   // It stalls in random bursts, holds off entirely while hold_rsp is set, and stays
   // ready throughout the final stretch.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_result();
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // One long hold-off of the receiver while the sender keeps offering items, so the
   // output register fills and the block has to stop accepting further requests.
   initial begin
      hold_rsp <= 1'b0;
      wait (accepted_items >= HOLD_AFTER);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Main sequence: reset, directed table, random traffic, then drain.
   initial begin
      int waited;
      reset             <= 1'b1;
      calm_phase        <= 1'b0;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_INS_FRONT;
      req_ch.position   <= '0;
      req_ch.item_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         for (int k = 0; k < DIRECTED_ROWS[r].repeats; k++) begin
            send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].position,
                         DIRECTED_ROWS[r].value + k);
            // Typed rows each cause a single result; the written-out expectation takes
            // the place of the predicted one, while the list copy stays updated.
            if (DIRECTED_ROWS[r].typed)
               pending_results[pending_results.size() - 1] = DIRECTED_ROWS[r].want;
         end
      end

      run_random_traffic();
      req_ch.valid <= 1'b0;

      // Wait for the outstanding results, then a little longer to catch stray items.
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d expected result items never arrived",
                                   pending_results.size()));

      if (mismatch_count == 0) begin
         $display("positional_ordered_list test passed");
      end else begin
         $display("positional_ordered_list test failed");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run.
   initial begin
      #5_000_000;
      $display("positional_ordered_list test failed");
      $finish;
   end

endmodule
